[rtl/sasrch_pkg.sv]
package sasrch_pkg;

  localparam int TEXT_DEPTH  = 1024;
  localparam int QUERY_DEPTH = 64;

  localparam int TA_W = $clog2(TEXT_DEPTH);        // text / rank / hit index
  localparam int TL_W = $clog2(TEXT_DEPTH + 1);    // lengths and counts
  localparam int QA_W = $clog2(QUERY_DEPTH);
  localparam int QL_W = $clog2(QUERY_DEPTH + 1);
  localparam int PS_W = TL_W + 1;                  // suffix start plus query offset

  typedef enum logic [1:0] {
    OP_WR_TEXT   = 2'd0,
    OP_WR_SUFFIX = 2'd1,
    OP_QUERY     = 2'd2,
    OP_READ_HIT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMP_LT = 2'd0,
    CMP_EQ = 2'd1,
    CMP_GT = 2'd2
  } cmp_t;

  typedef enum logic [5:0] {
    PH_LB_FIRST = 6'b000001,
    PH_LB_LAST  = 6'b000010,
    PH_LB_LOOP  = 6'b000100,
    PH_UB_FIRST = 6'b001000,
    PH_UB_LAST  = 6'b010000,
    PH_UB_LOOP  = 6'b100000
  } phase_t;

endpackage

[rtl/suffix_array_pattern_search_unit.sv]
// Loads and non-final query bytes: one transfer per cycle while idle, back to back, no result.
// Read hit: S_RD_WAIT takes the registered hit memory read and S_OUT loads the result; input
// is held off until then. Final query byte: S_START, then up to 2*(ceil(log2 n)+2) compares
// (suffix start read, then one character per S_C_POS/S_C_CMP pass; an S_LOOP bisect step
// precedes each loop compare), then an insertion sort of the hits, then the result in S_OUT.
// Reset (rst, synchronous): config, query, hit count and out_valid cleared; memories undefined.
module suffix_array_pattern_search_unit
  import sasrch_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [TL_W-1:0] text_length,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [1:0]      operation,
  input  logic [TA_W-1:0] address,
  input  logic [7:0]      text_byte,
  input  logic [TA_W-1:0] suffix_start,
  input  logic [7:0]      query_byte,
  input  logic            query_last,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            result_kind,
  output logic [1:0]      status,
  output logic [TL_W-1:0] hit_count,
  output logic [TA_W-1:0] first_rank,
  output logic [TA_W-1:0] last_rank,
  output logic [TA_W-1:0] hit_position
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_START    = 13'b0000000000010,
    S_C_ADDR   = 13'b0000000000100,
    S_C_POS    = 13'b0000000001000,
    S_C_CMP    = 13'b0000000010000,
    S_NEXT     = 13'b0000000100000,
    S_LOOP     = 13'b0000001000000,
    S_SORT_RD  = 13'b0000010000000,
    S_SORT_V   = 13'b0000100000000,
    S_SORT_J   = 13'b0001000000000,
    S_SORT_CMP = 13'b0010000000000,
    S_RD_WAIT  = 13'b0100000000000,
    S_OUT      = 13'b1000000000000
  } state_t;

  state_t st;

  // configuration and query bookkeeping
  logic [TL_W-1:0] tlen;
  logic [QL_W-1:0] qlen;
  logic            qovf;
  logic [TL_W-1:0] hits_found;

  // search registers
  phase_t          phase;
  logic [TL_W-1:0] lo, hi, lb, ub;
  logic [TA_W-1:0] mid;
  logic [QL_W-1:0] lcp_l, lcp_r;
  logic [TA_W-1:0] cr;       // rank under compare
  logic [QL_W-1:0] cj;       // query offset of compare
  cmp_t            cres;
  logic [QL_W-1:0] clcp;

  // sort registers
  logic [TL_W-1:0] si;
  logic [TA_W-1:0] sj;
  logic [TA_W-1:0] sv;
  logic [TA_W-1:0] rd_addr;

  // pending result
  logic            p_kind;
  status_t         p_status;
  logic [TL_W-1:0] p_count;
  logic [TA_W-1:0] p_first, p_last, p_pos;

  // memories
  logic [7:0]      text_mem   [TEXT_DEPTH];
  logic [TA_W-1:0] suffix_mem [TEXT_DEPTH];
  logic [7:0]      query_mem  [QUERY_DEPTH];
  logic [TA_W-1:0] hit_mem    [TEXT_DEPTH];
  logic [7:0]      text_q, query_q;
  logic [TA_W-1:0] suffix_q, hit_q;

  logic            text_we, suffix_we, query_we, hit_we;
  logic            text_re, suffix_re, query_re, hit_re;
  logic [TA_W-1:0] text_ra, suffix_ra, hit_ra, hit_wa, hit_wd;
  logic [QA_W-1:0] query_wa, query_ra;

  logic            in_xfer;
  logic [TL_W-1:0] n_used;
  logic [PS_W-1:0] pos;
  logic [TL_W-1:0] cnt;
  logic [QL_W-1:0] lcp_min;
  logic [TL_W:0]   mid_sum;

  assign cfg_ready = 1'b1;
  assign in_ready  = (st == S_IDLE);
  assign in_xfer   = in_valid && in_ready;

  // a length above the text depth counts as the full depth
  assign n_used  = (tlen > TL_W'(TEXT_DEPTH)) ? TL_W'(TEXT_DEPTH) : tlen;
  assign pos     = PS_W'(suffix_q) + PS_W'(cj);
  assign cnt     = (ub > lb) ? (ub - lb) : '0;
  assign lcp_min = (lcp_l < lcp_r) ? lcp_l : lcp_r;
  assign mid_sum = (TL_W+1)'(lo) + (TL_W+1)'(hi) + (TL_W+1)'(1);

  // memory port steering
  always_comb begin
    text_we   = in_xfer && (op_t'(operation) == OP_WR_TEXT);
    suffix_we = in_xfer && (op_t'(operation) == OP_WR_SUFFIX);
    query_we  = in_xfer && (op_t'(operation) == OP_QUERY) && (qlen < QL_W'(QUERY_DEPTH));
    query_wa  = qlen[QA_W-1:0];
    text_re   = (st == S_C_POS);
    text_ra   = pos[TA_W-1:0];
    query_re  = (st == S_C_POS);
    query_ra  = cj[QA_W-1:0];
    suffix_re = (st == S_C_ADDR) || ((st == S_SORT_RD) && (si != cnt));
    suffix_ra = (st == S_C_ADDR) ? cr : TA_W'(lb + si);
    hit_re    = 1'b0;
    hit_ra    = address;
    hit_we    = 1'b0;
    hit_wa    = sj;
    hit_wd    = sv;
    if (in_xfer && (op_t'(operation) == OP_READ_HIT)) begin
      hit_re = 1'b1;
    end
    if (st == S_SORT_J) begin
      if (sj == '0) begin
        hit_we = 1'b1;
      end else begin
        hit_re = 1'b1;
        hit_ra = sj - TA_W'(1);
      end
    end
    if (st == S_SORT_CMP) begin
      hit_we = 1'b1;
      if (hit_q > sv) begin
        hit_wd = hit_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text_we)   text_mem[address] <= text_byte;
    if (text_re)   text_q <= text_mem[text_ra];
  end

  always_ff @(posedge clk) begin
    if (suffix_we) suffix_mem[address] <= suffix_start;
    if (suffix_re) suffix_q <= suffix_mem[suffix_ra];
  end

  always_ff @(posedge clk) begin
    if (query_we) query_mem[query_wa] <= query_byte;
    if (query_re) query_q <= query_mem[query_ra];
  end

  always_ff @(posedge clk) begin
    if (hit_we) hit_mem[hit_wa] <= hit_wd;
    if (hit_re) hit_q <= hit_mem[hit_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      tlen       <= '0;
      qlen       <= '0;
      qovf       <= 1'b0;
      hits_found <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tlen <= text_length;
      end
      // S_OUT reloads the output register itself
      if (out_valid && out_ready && (st != S_OUT)) begin
        out_valid <= 1'b0;
      end

      unique case (st)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (op_t'(operation))
              OP_WR_TEXT, OP_WR_SUFFIX: ;
              OP_QUERY: begin
                if (qlen < QL_W'(QUERY_DEPTH)) begin
                  qlen <= qlen + QL_W'(1);
                end else begin
                  qovf <= 1'b1;
                end
                if (query_last) begin
                  st <= S_START;
                end
              end
              OP_READ_HIT: begin
                rd_addr <= address;
                st      <= S_RD_WAIT;
              end
            endcase
          end
        end

        S_START: begin
          p_kind  <= 1'b0;
          p_count <= '0;
          p_first <= '0;
          p_last  <= '0;
          p_pos   <= '0;
          priority if (n_used == '0) begin
            p_status   <= ST_EMPTY;
            hits_found <= '0;
            qlen       <= '0;
            qovf       <= 1'b0;
            st         <= S_OUT;
          end else if (qovf) begin
            p_status   <= ST_TOO_LONG;
            hits_found <= '0;
            qlen       <= '0;
            qovf       <= 1'b0;
            st         <= S_OUT;
          end else begin
            p_status <= ST_OK;
            phase    <= PH_LB_FIRST;
            cr       <= '0;
            cj       <= '0;
            st       <= S_C_ADDR;
          end
        end

        // suffix start read in flight
        S_C_ADDR: st <= S_C_POS;

        S_C_POS: begin
          priority if (cj >= qlen) begin
            cres <= CMP_EQ;
            clcp <= qlen;
            st   <= S_NEXT;
          end else if (pos >= PS_W'(n_used)) begin
            // suffix ran out before the query: it sorts below
            cres <= CMP_GT;
            clcp <= cj;
            st   <= S_NEXT;
          end else begin
            st <= S_C_CMP;
          end
        end

        S_C_CMP: begin
          priority if (query_q < text_q) begin
            cres <= CMP_LT;
            clcp <= cj;
            st   <= S_NEXT;
          end else if (query_q > text_q) begin
            cres <= CMP_GT;
            clcp <= cj;
            st   <= S_NEXT;
          end else begin
            cj <= cj + QL_W'(1);
            st <= S_C_POS;
          end
        end

        S_NEXT: begin
          unique case (phase)
            PH_LB_FIRST: begin
              if (cres != CMP_GT) begin
                lb    <= '0;
                phase <= PH_UB_FIRST;
                cr    <= '0;
                cj    <= '0;
                st    <= S_C_ADDR;
              end else begin
                lcp_l <= clcp;
                phase <= PH_LB_LAST;
                cr    <= TA_W'(n_used - TL_W'(1));
                cj    <= '0;
                st    <= S_C_ADDR;
              end
            end
            PH_LB_LAST: begin
              if (cres == CMP_GT) begin
                lb    <= n_used;
                phase <= PH_UB_FIRST;
                cr    <= '0;
                cj    <= '0;
                st    <= S_C_ADDR;
              end else begin
                lcp_r <= clcp;
                lo    <= '0;
                hi    <= n_used - TL_W'(1);
                phase <= PH_LB_LOOP;
                st    <= S_LOOP;
              end
            end
            PH_LB_LOOP: begin
              if (cres != CMP_GT) begin
                hi    <= TL_W'(mid);
                lcp_r <= clcp;
              end else begin
                lo    <= TL_W'(mid);
                lcp_l <= clcp;
              end
              st <= S_LOOP;
            end
            PH_UB_FIRST: begin
              if (cres == CMP_LT) begin
                ub <= '0;
                si <= '0;
                st <= S_SORT_RD;
              end else begin
                lcp_l <= clcp;
                phase <= PH_UB_LAST;
                cr    <= TA_W'(n_used - TL_W'(1));
                cj    <= '0;
                st    <= S_C_ADDR;
              end
            end
            PH_UB_LAST: begin
              if (cres != CMP_LT) begin
                ub <= n_used;
                si <= '0;
                st <= S_SORT_RD;
              end else begin
                lcp_r <= clcp;
                lo    <= '0;
                hi    <= n_used - TL_W'(1);
                phase <= PH_UB_LOOP;
                st    <= S_LOOP;
              end
            end
            PH_UB_LOOP: begin
              if (cres != CMP_LT) begin
                lo    <= TL_W'(mid);
                lcp_l <= clcp;
              end else begin
                hi    <= TL_W'(mid);
                lcp_r <= clcp;
              end
              st <= S_LOOP;
            end
            default: st <= S_IDLE;
          endcase
        end

        // bisect while the bracket is wider than one rank
        S_LOOP: begin
          if ((hi - lo) > TL_W'(1)) begin
            mid <= TA_W'(mid_sum >> 1);
            cr  <= TA_W'(mid_sum >> 1);
            cj  <= lcp_min;
            st  <= S_C_ADDR;
          end else if (phase == PH_LB_LOOP) begin
            lb    <= hi;
            phase <= PH_UB_FIRST;
            cr    <= '0;
            cj    <= '0;
            st    <= S_C_ADDR;
          end else begin
            ub <= lo + TL_W'(1);
            si <= '0;
            st <= S_SORT_RD;
          end
        end

        S_SORT_RD: begin
          if (si == cnt) begin
            hits_found <= cnt;
            p_count    <= cnt;
            if (cnt != '0) begin
              p_first <= TA_W'(lb);
              p_last  <= TA_W'(ub - TL_W'(1));
            end
            qlen <= '0;
            qovf <= 1'b0;
            st   <= S_OUT;
          end else begin
            sj <= TA_W'(si);
            st <= S_SORT_V;
          end
        end

        S_SORT_V: begin
          sv <= suffix_q;
          st <= S_SORT_J;
        end

        S_SORT_J: begin
          if (sj == '0) begin
            si <= si + TL_W'(1);
            st <= S_SORT_RD;
          end else begin
            st <= S_SORT_CMP;
          end
        end

        // shift the larger entry up, or drop the new value in place
        S_SORT_CMP: begin
          if (hit_q > sv) begin
            sj <= sj - TA_W'(1);
            st <= S_SORT_J;
          end else begin
            si <= si + TL_W'(1);
            st <= S_SORT_RD;
          end
        end

        S_RD_WAIT: begin
          p_kind  <= 1'b1;
          p_count <= hits_found;
          p_first <= '0;
          p_last  <= '0;
          if (TL_W'(rd_addr) < hits_found) begin
            p_status <= ST_OK;
            p_pos    <= hit_q;
          end else begin
            p_status <= ST_BAD_INDEX;
            p_pos    <= '0;
          end
          st <= S_OUT;
        end

        // hold until the output register is free
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            result_kind  <= p_kind;
            status       <= p_status;
            hit_count    <= p_count;
            first_rank   <= p_first;
            last_rank    <= p_last;
            hit_position <= p_pos;
            st           <= S_IDLE;
          end
        end

        default: st <= S_IDLE;
      endcase
    end
  end

  a_out_loads: assert property (@(posedge clk) disable iff (rst)
    (st == S_OUT) && (!out_valid || out_ready) |=> out_valid)
    else $error("result not loaded from S_OUT");

  a_qlen_range: assert property (@(posedge clk) disable iff (rst)
    qlen <= QL_W'(QUERY_DEPTH))
    else $error("query length past depth");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result_kind && (status != ST_OK) |-> (hit_count == '0))
    else $error("error summary with nonzero count");

  a_read_path: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (op_t'(operation) == OP_READ_HIT) |=> (st == S_RD_WAIT))
    else $error("read hit did not enter wait state");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import sasrch_pkg::*;

  localparam int LIMIT  = 60000000;
  localparam int SETTLE = 20;
  localparam int ITEMS  = 1450;

  typedef struct {
    bit        kind;
    bit [1:0]  status;
    bit [10:0] count;
    bit [9:0]  low_rank;
    bit [9:0]  high_rank;
    bit [9:0]  position;
  } search_result_t;

  // Predicts summaries and hit reads; holds the results still owed by the block.
  class search_scoreboard;
    bit [7:0]  text_mem[TEXT_DEPTH];
    bit [9:0]  rank_mem[TEXT_DEPTH];
    bit [7:0]  pattern[QUERY_DEPTH];
    int        pattern_len;
    bit        pattern_ovf;
    bit [9:0]  sorted_hits[TEXT_DEPTH];
    int        hit_total;
    int        length_reg;
    int        errors;
    search_result_t owed[$];

    function void set_length(int v);
      length_reg = v;
    endfunction

    // -1: pattern below suffix, 0: pattern is a prefix, +1: pattern above.
    function int compare_rank(int n, int r, int k, output int lcp);
      int start;
      int j;
      start = rank_mem[r];
      for (j = k; j < pattern_len; j++) begin
        if (start + j >= n) begin
          lcp = j;
          return 1;
        end
        if (pattern[j] < text_mem[start + j]) begin
          lcp = j;
          return -1;
        end
        if (pattern[j] > text_mem[start + j]) begin
          lcp = j;
          return 1;
        end
      end
      lcp = pattern_len;
      return 0;
    endfunction

    function int lowest_match(int n);
      int lo, hi, lft, rgt, mid, lm;
      lo = 0;
      hi = n - 1;
      if (compare_rank(n, 0, 0, lft) <= 0) return 0;
      if (compare_rank(n, n - 1, 0, rgt) > 0) return n;
      while (hi - lo > 1) begin
        mid = (lo + hi + 1) / 2;
        if (compare_rank(n, mid, (lft < rgt) ? lft : rgt, lm) <= 0) begin
          hi = mid;
          rgt = lm;
        end else begin
          lo = mid;
          lft = lm;
        end
      end
      return hi;
    endfunction

    function int past_highest_match(int n);
      int lo, hi, lft, rgt, mid, lm;
      lo = 0;
      hi = n - 1;
      if (compare_rank(n, 0, 0, lft) < 0) return 0;
      if (compare_rank(n, n - 1, 0, rgt) >= 0) return n;
      while (hi - lo > 1) begin
        mid = (lo + hi + 1) / 2;
        if (compare_rank(n, mid, (lft < rgt) ? lft : rgt, lm) >= 0) begin
          lo = mid;
          lft = lm;
        end else begin
          hi = mid;
          rgt = lm;
        end
      end
      return lo + 1;
    endfunction

    function search_result_t search_summary();
      search_result_t s;
      int n, lo, hi, cnt, i, j;
      bit [9:0] v;
      s = '{default: 0};
      n = (length_reg > TEXT_DEPTH) ? TEXT_DEPTH : length_reg;
      hit_total = 0;
      if (n == 0) begin
        s.status = ST_EMPTY;
        return s;
      end
      if (pattern_ovf) begin
        s.status = ST_TOO_LONG;
        return s;
      end
      lo = lowest_match(n);
      hi = past_highest_match(n);
      cnt = (hi > lo) ? hi - lo : 0;
      // insertion sort of the matching starts, ascending
      for (i = 0; i < cnt; i++) begin
        v = rank_mem[lo + i];
        j = i;
        while (j > 0 && sorted_hits[j - 1] > v) begin
          sorted_hits[j] = sorted_hits[j - 1];
          j--;
        end
        sorted_hits[j] = v;
      end
      hit_total = cnt;
      s.count = 11'(cnt);
      if (cnt > 0) begin
        s.low_rank = 10'(lo);
        s.high_rank = 10'(hi - 1);
      end
      return s;
    endfunction

    function void note_item(op_t op, bit [9:0] addr, bit [7:0] tbyte, bit [9:0] sstart,
                            bit [7:0] qbyte, bit qlast);
      search_result_t s;
      case (op)
        OP_WR_TEXT: text_mem[addr] = tbyte;
        OP_WR_SUFFIX: rank_mem[addr] = sstart;
        OP_QUERY: begin
          if (pattern_len < QUERY_DEPTH) begin
            pattern[pattern_len] = qbyte;
            pattern_len++;
          end else begin
            pattern_ovf = 1;
          end
          if (qlast) begin
            owed = {owed, search_summary()};
            pattern_len = 0;
            pattern_ovf = 0;
          end
        end
        default: begin
          s = '{default: 0};
          s.kind = 1;
          s.count = 11'(hit_total);
          if (addr < hit_total) begin
            s.status = ST_OK;
            s.position = sorted_hits[addr];
          end else begin
            s.status = ST_BAD_INDEX;
          end
          owed = {owed, s};
        end
      endcase
    endfunction

    function void check_result(search_result_t got);
      search_result_t want;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result kind=%0d status=%0d", $time, got.kind, got.status);
        errors++;
        return;
      end
      want = owed.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.count != want.count) begin
        $display("%0t: hit_count expected %0d actual %0d", $time, want.count, got.count);
        errors++;
      end
      if (got.low_rank != want.low_rank) begin
        $display("%0t: first_rank expected %0d actual %0d", $time, want.low_rank,
                 got.low_rank);
        errors++;
      end
      if (got.high_rank != want.high_rank) begin
        $display("%0t: last_rank expected %0d actual %0d", $time, want.high_rank,
                 got.high_rank);
        errors++;
      end
      if (got.position != want.position) begin
        $display("%0t: hit_position expected %0d actual %0d", $time, want.position,
                 got.position);
        errors++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [TL_W-1:0] cfg_length;
  logic            in_valid;
  logic            in_ready;
  logic [1:0]      operation;
  logic [TA_W-1:0] address;
  logic [7:0]      text_byte;
  logic [TA_W-1:0] suffix_start;
  logic [7:0]      query_byte;
  logic            query_last;
  logic            out_valid;
  logic            out_ready;
  logic            result_kind;
  logic [1:0]      status;
  logic [TL_W-1:0] hit_count;
  logic [TA_W-1:0] first_rank;
  logic [TA_W-1:0] last_rank;
  logic [TA_W-1:0] hit_position;

  suffix_array_pattern_search_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .text_length(cfg_length),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation), .address(address),
    .text_byte(text_byte), .suffix_start(suffix_start), .query_byte(query_byte),
    .query_last(query_last),
    .out_valid(out_valid), .out_ready(out_ready), .result_kind(result_kind),
    .status(status), .hit_count(hit_count), .first_rank(first_rank),
    .last_rank(last_rank), .hit_position(hit_position)
  );

  search_scoreboard expected_results = new();

  // Text as loaded in the current phase; used to build a proper suffix array.
  bit [7:0] text_copy[TEXT_DEPTH];
  int       rank_order[TEXT_DEPTH];
  bit [7:0] query_bytes[$];
  int       burst_left;
  bit       no_gaps;
  int       items_sent;
  int       cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("suffix_array_pattern_search_unit test failed");
      $finish;
    end
  end

  // Receiver: rotate through four stall patterns, including
  // stretches where every result is taken at once.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
    end else begin
      case ((cycles / 300) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ((cycles % 4) == 0);
        default: out_ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk) begin
    search_result_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = result_kind;
      got.status = status;
      got.count = hit_count;
      got.low_rank = first_rank;
      got.high_rank = last_rank;
      got.position = hit_position;
      expected_results.check_result(got);
    end
  end

  // Drive one input transfer; open a random gap when the current burst is used up.
  task automatic send_item(op_t op, int addr, int tbyte, int sstart, int qbyte, bit qlast);
    int gap;
    @(negedge clk);
    if (!no_gaps) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    operation <= op;
    address <= TA_W'(addr);
    text_byte <= 8'(tbyte);
    suffix_start <= TA_W'(sstart);
    query_byte <= 8'(qbyte);
    query_last <= qlast;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.note_item(op, TA_W'(addr), 8'(tbyte), TA_W'(sstart), 8'(qbyte),
                               qlast);
    items_sent++;
  endtask

  // Hold input until every owed result has come back and the block is quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.owed.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_length(int v);
    drain();
    @(negedge clk);
    cfg_length <= TL_W'(v);
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    expected_results.set_length(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_query();
    int i;
    for (i = 0; i < query_bytes.size(); i++)
      send_item(OP_QUERY, $urandom_range(0, 1023), $urandom_range(0, 255),
                $urandom_range(0, 1023), query_bytes[i], i == query_bytes.size() - 1);
  endtask

  task automatic read_hit(int idx);
    send_item(OP_READ_HIT, idx, $urandom_range(0, 255), $urandom_range(0, 1023),
              $urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // Suffixes that run out first sort lower.
  function automatic bit suffix_below(int a, int b, int n);
    int i;
    for (i = 0; a + i < n && b + i < n; i++)
      if (text_copy[a + i] != text_copy[b + i]) return text_copy[a + i] < text_copy[b + i];
    return a + i >= n && b + i < n;
  endfunction

  // Load n text bytes from an alphabet of the given size and a suffix array;
  // scramble corrupts some entries, including starts past the text end.
  task automatic load_text(int n, int alpha, bit scramble);
    int i, j, v;
    for (i = 0; i < n; i++) begin
      text_copy[i] = 8'((alpha >= 256) ? $urandom_range(0, 255)
                                       : $urandom_range(0, alpha - 1));
      send_item(OP_WR_TEXT, i, text_copy[i], $urandom_range(0, 1023),
                $urandom_range(0, 255), $urandom_range(0, 1));
    end
    for (i = 0; i < n; i++) begin
      v = i;
      j = i;
      while (j > 0 && suffix_below(v, rank_order[j - 1], n)) begin
        rank_order[j] = rank_order[j - 1];
        j--;
      end
      rank_order[j] = v;
    end
    for (i = 0; i < n; i++) begin
      v = rank_order[i];
      if (scramble && $urandom_range(0, 3) == 0) v = $urandom_range(0, 1023);
      send_item(OP_WR_SUFFIX, i, $urandom_range(0, 255), v,
                $urandom_range(0, 255), $urandom_range(0, 1));
    end
  endtask

  // Mostly queries cut from the text, so the searches find real ranges.
  task automatic random_ops(int n, int alpha, int count);
    int k, r, len, start, i;
    for (k = 0; k < count && items_sent < ITEMS; k++) begin
      r = $urandom_range(0, 99);
      query_bytes.delete();
      if (r < 55 && n > 0) begin
        len = $urandom_range(1, 8);
        start = $urandom_range(0, n - 1);
        for (i = 0; i < len; i++)
          query_bytes = {query_bytes, 8'((start + i < n) ? text_copy[start + i]
                                         : ((alpha >= 256) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, alpha - 1)))};
        send_query();
      end else if (r < 70) begin
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++)
          query_bytes = {query_bytes, 8'((alpha >= 256) ? $urandom_range(0, 255)
                                                        : $urandom_range(0, alpha - 1))};
        send_query();
      end else if (r < 74) begin
        len = $urandom_range(QUERY_DEPTH - 1, QUERY_DEPTH + 6);
        for (i = 0; i < len; i++) query_bytes = {query_bytes, 8'($urandom_range(0, 255))};
        send_query();
      end else if (r < 90 && expected_results.hit_total > 0) begin
        read_hit($urandom_range(0, expected_results.hit_total - 1));
      end else begin
        read_hit(($urandom_range(0, 1) == 1) ? $urandom_range(0, 1023)
                 : $urandom_range(0, expected_results.hit_total + 2));
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  task automatic run_phase(int len_cfg, int alpha, bit scramble, int count);
    int n;
    n = (len_cfg > TEXT_DEPTH) ? TEXT_DEPTH : len_cfg;
    no_gaps = ($urandom_range(0, 3) == 0);
    write_length(len_cfg);
    load_text(n, alpha, scramble);
    random_ops(n, alpha, count);
  endtask

  initial begin
    int i, r, len_cfg, alpha;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_length = '0;
    in_valid = 1'b0;
    operation = OP_WR_TEXT;
    address = '0;
    text_byte = '0;
    suffix_start = '0;
    query_byte = '0;
    query_last = 1'b0;
    burst_left = 0;
    no_gaps = 0;
    items_sent = 0;
    cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty text: a plain query and an overlong one both report empty text;
    // a read with no hits is out of range.
    write_length(0);
    query_bytes = '{8'h41};
    send_query();
    query_bytes.delete();
    for (i = 0; i < QUERY_DEPTH + 2; i++) query_bytes = {query_bytes, 8'hFF};
    send_query();
    read_hit(0);

    // One-byte text: a hit, a miss, reads in and past range, a query running
    // past the text end, a full-depth query and an overlong one.
    write_length(1);
    load_text(1, 256, 0);
    query_bytes = '{text_copy[0]};
    send_query();
    read_hit(0);
    read_hit(1);
    read_hit(1023);
    query_bytes = '{~text_copy[0]};
    send_query();
    query_bytes = '{text_copy[0], 8'h00};
    send_query();
    query_bytes.delete();
    for (i = 0; i < QUERY_DEPTH; i++) query_bytes = {query_bytes, 8'h00};
    send_query();
    query_bytes = {query_bytes, 8'h00};
    send_query();

    // Repetitive text: many hits, sorted ascending.
    write_length(12);
    load_text(12, 1, 0);
    query_bytes = '{8'h00};
    send_query();
    read_hit(0);
    read_hit(11);
    read_hit(12);

    while (items_sent < ITEMS - 60) begin
      r = $urandom_range(0, 9);
      if (r < 7) len_cfg = $urandom_range(1, 48);
      else if (r == 7) len_cfg = $urandom_range(2, 8);
      else if (r == 8) len_cfg = 0;
      else len_cfg = $urandom_range(49, 100);
      r = $urandom_range(0, 2);
      alpha = (r == 0) ? 2 : (r == 1) ? 4 : 256;
      run_phase(len_cfg, alpha, $urandom_range(0, 5) == 0, $urandom_range(10, 25));
    end

    drain();
    if (expected_results.errors == 0) begin
      $display("suffix_array_pattern_search_unit test passed");
    end else begin
      $display("suffix_array_pattern_search_unit test failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/sasrch_pkg.sv
rtl/suffix_array_pattern_search_unit.sv
tb/tb.sv
